// File: rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants and types for the page allocator core.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // The used-page bitmap is stored as words of this many bits.
    localparam int WORD_BITS = 8;
    localparam int OFS_BITS  = 3;

    // Single set bit in the lowest position of a bitmap word.
    localparam logic [WORD_BITS-1:0] BIT0 = 8'h01;

    // Operation codes carried on the mode input.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Result of looking for a free page inside one bitmap word.
    typedef struct packed {
        logic                found;
        logic [OFS_BITS-1:0] ofs;
    } t_scan_res;

endpackage

// File: rtl/core/bitmap_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator unit
// Hands out the lowest free page, frees pages and answers free-page queries.
// ----------------------------------------------------------------------------
// Sequence: a rejected command reports in the cycle after start; query, free and an
//   allocate whose next free page sits in the same bitmap word pass READ and EXEC.
// An allocate that must look further adds a SCAN_CHK step for each more word read.
// Throughput: one command at a time; busy is high until the result strobes.
// Reset clears the bitmap by writing one word per cycle over all ceil(PAGE_COUNT / 8)
//   words, with busy held high; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit #(
    parameter int PAGE_COUNT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_page_index,
    output logic        o_done,
    output logic        o_ok,
    output logic [11:0] o_granted_page,
    output logic [12:0] o_pages_in_use
);

    // Bitmap geometry. Page pointers and the use count must also hold
    // PAGE_COUNT itself, which marks a full bitmap.
    localparam int Words  = (PAGE_COUNT + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
    localparam int AddrW  = (Words > 1) ? $clog2(Words) : 1;
    localparam int PageW  = $clog2(PAGE_COUNT + 1);
    localparam logic [AddrW-1:0] LastWord = AddrW'(Words - 1);
    localparam logic [PageW-1:0] PageFull = PageW'(PAGE_COUNT);
    localparam logic [PageW-1:0] PageLast = PageW'(PAGE_COUNT - 1);

    // Sequencer: CLEAR sweeps the bitmap after reset, READ fetches the word
    // that holds the target page, EXEC updates it and SCAN_CHK walks upward
    // one word per cycle looking for the next free page after an allocate.
    typedef enum logic [4:0] {
        S_CLEAR    = 5'b00001,
        S_IDLE     = 5'b00010,
        S_READ     = 5'b00100,
        S_EXEC     = 5'b01000,
        S_SCAN_CHK = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [AddrW-1:0]  r_clr_addr, n_clr_addr;
    logic [AddrW-1:0]  r_scan_addr, n_scan_addr;
    logic [PageW-1:0]  r_lowest_free, n_lowest_free;
    logic [PageW-1:0]  r_count, n_count;
    logic              r_done, n_done;

    // Transaction payload; no reset needed.
    logic [1:0]        r_op, n_op;
    logic [PageW-1:0]  r_page, n_page;
    logic              r_ok, n_ok;
    logic [11:0]       r_grant, n_grant;

    // Bitmap RAM access.
    logic                          w_we;
    logic [AddrW-1:0]              w_waddr;
    logic [bpa_pkg::WORD_BITS-1:0] w_wdata;
    logic [AddrW-1:0]              w_raddr;
    logic [bpa_pkg::WORD_BITS-1:0] w_rdata;

    // Decode of the target page and the shared word scanner.
    logic [AddrW-1:0]              w_word_addr;
    logic [bpa_pkg::OFS_BITS-1:0]  w_ofs;
    logic [bpa_pkg::WORD_BITS-1:0] w_bit_sel;
    logic [bpa_pkg::WORD_BITS-1:0] w_skip;
    logic [AddrW-1:0]              w_scan_addr;
    bpa_pkg::t_scan_res            w_scan;
    logic                          w_in_range;

    assign w_word_addr = AddrW'(r_page >> bpa_pkg::OFS_BITS);
    assign w_ofs       = r_page[bpa_pkg::OFS_BITS-1:0];
    assign w_bit_sel   = bpa_pkg::BIT0 << w_ofs;
    assign w_in_range  = 32'(i_page_index) < 32'(PAGE_COUNT);

    bpa_ram #(
        .WIDTH  (bpa_pkg::WORD_BITS),
        .DEPTH  (Words),
        .ADDR_W (AddrW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The scanner looks at the word just read. In EXEC it ignores the pages
    // at and below the one being granted; while walking upward it sees all.
    assign w_scan_addr = (r_state == S_EXEC) ? w_word_addr : r_scan_addr;

    bpa_word_scan #(
        .PAGE_COUNT (PAGE_COUNT),
        .ADDR_W     (AddrW)
    ) u_word_scan (
        .i_word (w_rdata),
        .i_addr (w_scan_addr),
        .i_skip (w_skip),
        .o_res  (w_scan)
    );

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_scan_addr   = r_scan_addr;
        n_lowest_free = r_lowest_free;
        n_count       = r_count;
        n_done        = 1'b0;
        n_op          = r_op;
        n_page        = r_page;
        n_ok          = r_ok;
        n_grant       = r_grant;
        w_we          = 1'b0;
        w_waddr       = w_word_addr;
        w_wdata       = w_rdata;
        w_raddr       = w_word_addr;
        w_skip        = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LastWord) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_op = i_mode;
                    // Commands rejected up front (full bitmap, page out of range, unknown mode) are answered at once.
                    priority if (i_mode == bpa_pkg::MODE_ALLOC) begin
                        if (r_lowest_free == PageFull) begin
                            n_done  = 1'b1;
                            n_ok    = 1'b0;
                            n_grant = '0;
                        end else begin
                            n_page  = r_lowest_free;
                            n_state = S_READ;
                        end
                    end else if ((i_mode == bpa_pkg::MODE_FREE ||
                                  i_mode == bpa_pkg::MODE_QUERY) && w_in_range) begin
                        n_page  = PageW'(i_page_index);
                        n_state = S_READ;
                    end else begin
                        n_done  = 1'b1;
                        n_ok    = 1'b0;
                        n_grant = '0;
                    end
                end
            end

            S_READ: begin
                n_state = S_EXEC;
            end

            S_EXEC: begin
                priority if (r_op == bpa_pkg::MODE_ALLOC) begin
                    // The pointer always names a free page, so this succeeds.
                    w_we    = 1'b1;
                    w_wdata = w_rdata | w_bit_sel;
                    w_skip  = (w_bit_sel << 1) - bpa_pkg::BIT0;
                    n_count = r_count + 1'b1;
                    n_ok    = 1'b1;
                    n_grant = 12'(r_page);
                    if (r_count == PageLast) begin
                        n_lowest_free = PageFull;
                        n_done        = 1'b1;
                        n_state       = S_IDLE;
                    end else if (w_scan.found) begin
                        n_lowest_free = PageW'({w_word_addr, w_scan.ofs});
                        n_done        = 1'b1;
                        n_state       = S_IDLE;
                    end else if (w_word_addr == LastWord) begin
                        n_lowest_free = PageFull;
                        n_done        = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        w_raddr     = w_word_addr + 1'b1;
                        n_scan_addr = w_word_addr + 1'b1;
                        n_state     = S_SCAN_CHK;
                    end
                end else if (r_op == bpa_pkg::MODE_FREE) begin
                    n_grant = '0;
                    if ((w_rdata & w_bit_sel) != '0) begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata & ~w_bit_sel;
                        n_count = r_count - 1'b1;
                        n_ok    = 1'b1;
                        if (r_lowest_free > r_page) begin
                            n_lowest_free = r_page;
                        end
                    end else begin
                        n_ok = 1'b0;
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_grant = '0;
                    n_ok    = ((w_rdata & w_bit_sel) == '0);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_SCAN_CHK: begin
                if (w_scan.found) begin
                    n_lowest_free = PageW'({r_scan_addr, w_scan.ofs});
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else if (r_scan_addr == LastWord) begin
                    n_lowest_free = PageFull;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    w_raddr     = r_scan_addr + 1'b1;
                    n_scan_addr = r_scan_addr + 1'b1;
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_scan_addr   <= '0;
            r_lowest_free <= '0;
            r_count       <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_scan_addr   <= n_scan_addr;
            r_lowest_free <= n_lowest_free;
            r_count       <= n_count;
            r_done        <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_page  <= n_page;
        r_ok    <= n_ok;
        r_grant <= n_grant;
    end

    // The use count changes when EXEC updates the bitmap, which can come before
    // the result strobe of an allocate that scans further; it is shown directly.
    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_granted_page = r_grant;
    assign o_pages_in_use = 13'(r_count);

`ifndef ASSERT_OFF
    // A full bitmap and a pointer at the page count go together.
    a_full_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_lowest_free == PageFull) == (r_count == PageFull)))
        else $error("lowest free pointer and use count disagree");

    // An accepted transaction either starts work or answers next cycle.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ((r_state != S_IDLE) || r_done))
        else $error("accepted transaction was dropped");

    // The bitmap is only written by the clear sweep or a command update.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_CLEAR) || (r_state == S_EXEC)))
        else $error("bitmap written outside clear or update");

    // No result during the clear sweep.
    a_no_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_done)
        else $error("result strobed during bitmap clear");
`endif

endmodule

// File: rtl/core/bpa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bpa_word_scan.sv
// ----------------------------------------------------------------------------
// Bitmap word scanner
// Finds the lowest free, in-range page of one bitmap word.
// ----------------------------------------------------------------------------
module bpa_word_scan #(
    parameter int PAGE_COUNT = 4096,
    parameter int ADDR_W     = 9
) (
    input  logic [bpa_pkg::WORD_BITS-1:0] i_word,
    input  logic [ADDR_W-1:0]             i_addr,
    input  logic [bpa_pkg::WORD_BITS-1:0] i_skip,
    output bpa_pkg::t_scan_res            o_res
);

    logic [bpa_pkg::WORD_BITS-1:0] w_free;

    // A page is a candidate when its bit is clear, it is not skipped and it
    // lies below the page count.
    always_comb begin
        for (int k = 0; k < bpa_pkg::WORD_BITS; k++) begin
            w_free[k] = !i_word[k] && !i_skip[k] &&
                        (((32'(i_addr) << bpa_pkg::OFS_BITS) | 32'(k)) < 32'(PAGE_COUNT));
        end
    end

    always_comb begin
        o_res.found = |w_free;
        o_res.ofs   = '0;
        for (int k = bpa_pkg::WORD_BITS - 1; k >= 0; k--) begin
            if (w_free[k]) begin
                o_res.ofs = bpa_pkg::OFS_BITS'(k);
            end
        end
    end

endmodule
